// ===== hdl/matrix_inverse_cofactor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix inverse block
// Each macro expands to a labeled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_COFACTOR_MACROS_SVH
`define MATRIX_INVERSE_COFACTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MIC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define MIC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MIC_ASSERT_NOW(label, clk, rstn, ante, cons, msg)

`define MIC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hdl/mic_pkg.sv =====
// ----------------------------------------------------------------------------
// mic_pkg
// Types, widths and small lookup functions shared by the matrix inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package mic_pkg;

    localparam int ORDER    = 4;
    localparam int CELLS    = ORDER * ORDER;
    localparam int SIZE_W   = 3;
    localparam int CNT_W    = 5;
    localparam int IDX_W    = 4;
    localparam int ELEM_W   = 12;
    localparam int COF_W    = 37;
    localparam int DET_W    = 50;
    localparam int FRAC_W   = 16;
    localparam int QUO_W    = COF_W + FRAC_W;
    localparam int VAL_W    = 32;
    localparam int TERMS    = 6;

    typedef logic [1:0] pos_t;

    // one loaded matrix waiting for the back end
    typedef struct packed {
        logic [SIZE_W-1:0] order;
        logic              bank;
    } job_t;

    // column picked in a given minor row by each term of a 3x3 determinant
    function automatic pos_t perm_col(input logic [2:0] term, input pos_t row);
        logic [5:0] cols;
        begin
            unique case (term)
                3'd0:    cols = {2'd0, 2'd1, 2'd2};
                3'd1:    cols = {2'd1, 2'd2, 2'd0};
                3'd2:    cols = {2'd2, 2'd0, 2'd1};
                3'd3:    cols = {2'd0, 2'd2, 2'd1};
                3'd4:    cols = {2'd2, 2'd1, 2'd0};
                3'd5:    cols = {2'd1, 2'd0, 2'd2};
                default: cols = '0;
            endcase
            unique case (row)
                2'd0:    perm_col = cols[5:4];
                2'd1:    perm_col = cols[3:2];
                default: perm_col = cols[1:0];
            endcase
        end
    endfunction

    // odd permutations carry a minus sign
    function automatic logic perm_odd(input logic [2:0] term);
        perm_odd = (term >= 3'd3);
    endfunction

    // map a minor index back to the full matrix, skipping the excluded line
    function automatic pos_t skip_pos(input pos_t k, input pos_t excl);
        skip_pos = (k < excl) ? k : pos_t'(k + 2'd1);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mic_ram.sv =====
// ----------------------------------------------------------------------------
// mic_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mic_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/mic_front.sv =====
// ----------------------------------------------------------------------------
// mic_front
// Size register and element loader; hands each full matrix to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mic_front
    import mic_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_matrix_size,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ELEM_W-1:0] s_element,
    input  wire logic              slot_free,
    output logic                   ram_we,
    output logic [IDX_W:0]         ram_waddr,
    output logic [ELEM_W-1:0]      ram_wdata,
    output logic                   push,
    output job_t                   push_job
);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              bank_reg, bank_next;
    logic [SIZE_W-1:0] order;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  cnt_inc;
    logic              accept;

    always_comb begin
        priority if (size_reg == '0) begin
            order = SIZE_W'(1);
        end else if (size_reg > SIZE_W'(ORDER)) begin
            order = SIZE_W'(ORDER);
        end else begin
            order = size_reg;
        end
    end

    assign total     = CNT_W'(CNT_W'(order) * CNT_W'(order));
    assign cfg_ready = 1'b1;
    assign s_ready   = slot_free;
    assign accept    = s_valid && s_ready;
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    assign ram_we    = accept;
    assign ram_waddr = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign ram_wdata = s_element;

    assign push           = accept && (cnt_inc >= total);
    assign push_job.order = order;
    assign push_job.bank  = bank_reg;

    always_comb begin
        size_next = size_reg;
        cnt_next  = cnt_reg;
        bank_next = bank_reg;
        if (cfg_valid && cfg_ready) begin
            size_next = cfg_matrix_size;
        end
        if (accept) begin
            if (push) begin
                cnt_next  = '0;
                bank_next = !bank_reg;
            end else begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_W'(ORDER);
            cnt_reg  <= '0;
            bank_reg <= 1'b0;
        end else begin
            size_reg <= size_next;
            cnt_reg  <= cnt_next;
            bank_reg <= bank_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mic_queue.sv =====
// ----------------------------------------------------------------------------
// mic_queue
// Two-entry job queue between loader and compute engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_inverse_cofactor_macros.svh"

module mic_queue
    import mic_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      nonempty,
    output logic [1:0] count
);

    job_t       ent_reg [2];
    job_t       ent_next [2];
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        ent_next[0] = ent_reg[0];
        ent_next[1] = ent_reg[1];
        cnt_next    = cnt_reg;
        if (pop) begin
            ent_next[0] = ent_reg[1];
        end
        if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                ent_next[0] = push_job;
            end else begin
                ent_next[1] = push_job;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                ent_next[0] = push_job;
            end else begin
                ent_next[1] = push_job;
            end
            cnt_next = cnt_reg + 2'd1;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign head     = ent_reg[0];
    assign nonempty = (cnt_reg != 2'd0);
    assign count    = cnt_reg;

    `MIC_ASSERT_NOW(a_no_overflow, aclk, aresetn, push && !pop, cnt_reg != 2'd2,
                    "queue overflow")
    `MIC_ASSERT_NOW(a_no_underflow, aclk, aresetn, pop, cnt_reg != 2'd0,
                    "queue underflow")

endmodule

`default_nettype wire

// ===== hdl/mic_back.sv =====
// ----------------------------------------------------------------------------
// mic_back
// Compute engine: cofactors by a sequenced 3x3 expansion of the padded 4x4
// matrix, determinant, restoring divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_inverse_cofactor_macros.svh"

module mic_back
    import mic_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    input  wire job_t              job,
    output logic                   job_pop,
    output logic                   busy,
    output logic [IDX_W:0]         ram_raddr,
    input  wire logic [ELEM_W-1:0] ram_rdata,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [VAL_W-1:0]       m_inverse_value,
    output logic                   m_singular,
    output logic                   m_saturated,
    output logic                   m_last
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_TERM = 6'b000010,
        ST_COF  = 6'b000100,
        ST_DMUL = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    localparam logic [QUO_W-1:0] POS_MAX = QUO_W'(64'h7FFF_FFFF);
    localparam logic [QUO_W-1:0] NEG_MAX = QUO_W'(64'h8000_0000);
    localparam logic [5:0]       DIV_LAST = 6'(QUO_W - 1);

    state_t                   state_reg, state_next;
    logic [SIZE_W-1:0]        order_reg, order_next;
    logic                     bank_reg, bank_next;
    logic                     detph_reg, detph_next;
    pos_t                     r_reg, r_next, c_reg, c_next;
    pos_t                     oi_reg, oi_next, oj_reg, oj_next;
    logic [2:0]               term_reg, term_next;
    logic [1:0]               step_reg, step_next;
    logic signed [ELEM_W-1:0] x_reg, x_next;
    logic signed [2*ELEM_W-1:0] p_reg, p_next;
    logic signed [COF_W-1:0]  acc_reg, acc_next;
    logic signed [COF_W-1:0]  cof_reg, cof_next;
    logic signed [DET_W-1:0]  det_reg, det_next;
    logic [DET_W-1:0]         rem_reg, rem_next;
    logic [DET_W-1:0]         dmag_reg, dmag_next;
    logic [QUO_W-1:0]         dq_reg, dq_next;
    logic                     neg_reg, neg_next;
    logic                     sing_reg, sing_next;
    logic [5:0]               bits_reg, bits_next;
    logic                     pad_use_reg, pad_one_reg;
    logic                     ov_reg, ov_next;
    logic [VAL_W-1:0]         oval_reg, oval_next;
    logic                     osing_reg, osing_next;
    logic                     osat_reg, osat_next;
    logic                     olast_reg, olast_next;

    pos_t                     fi, fj;
    logic [IDX_W-1:0]         fidx;
    logic signed [ELEM_W-1:0] elem;
    logic signed [3*ELEM_W-1:0] pz;
    logic signed [ELEM_W+COF_W-1:0] ac;
    logic                     term_neg;
    logic [COF_W-1:0]         cmag;
    logic [DET_W:0]           shifted;
    logic                     ge;
    logic                     sat_pos, sat_neg;
    logic                     is_last;
    pos_t                     lastpos;

    // element fetch: outside the n x n corner the matrix reads as identity
    always_comb begin
        fi = '0;
        fj = '0;
        unique case (state_reg)
            ST_TERM: begin
                fi = skip_pos(step_reg, r_reg);
                fj = skip_pos(perm_col(term_reg, step_reg), c_reg);
            end
            ST_COF: begin
                fi = '0;
                fj = c_reg;
            end
            default: begin
                fi = '0;
                fj = '0;
            end
        endcase
    end

    assign fidx = IDX_W'(CNT_W'(fi) * CNT_W'(order_reg) + CNT_W'(fj));
    assign ram_raddr = {bank_reg, fidx};

    always_ff @(posedge aclk) begin
        pad_use_reg <= !((SIZE_W'(fi) < order_reg) && (SIZE_W'(fj) < order_reg));
        pad_one_reg <= (fi == fj);
    end

    assign elem = pad_use_reg ? (pad_one_reg ? ELEM_W'(1) : ELEM_W'(0))
                              : $signed(ram_rdata);
    assign pz   = p_reg * elem;
    assign ac   = elem * cof_reg;
    assign term_neg = perm_odd(term_reg) ^ r_reg[0] ^ c_reg[0];
    assign cmag = acc_reg[COF_W-1] ? COF_W'(-acc_reg) : COF_W'(acc_reg);
    assign shifted = {rem_reg, dq_reg[QUO_W-1]};
    assign ge = (shifted >= {1'b0, dmag_reg});
    assign sat_pos = !neg_reg && (dq_reg > POS_MAX);
    assign sat_neg = neg_reg && (dq_reg > NEG_MAX);
    assign lastpos = pos_t'(order_reg - SIZE_W'(1));
    assign is_last = (oi_reg == lastpos) && (oj_reg == lastpos);

    always_comb begin
        state_next = state_reg;
        order_next = order_reg;
        bank_next  = bank_reg;
        detph_next = detph_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        oi_next    = oi_reg;
        oj_next    = oj_reg;
        term_next  = term_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        p_next     = p_reg;
        acc_next   = acc_reg;
        cof_next   = cof_reg;
        det_next   = det_reg;
        rem_next   = rem_reg;
        dmag_next  = dmag_reg;
        dq_next    = dq_reg;
        neg_next   = neg_reg;
        sing_next  = sing_reg;
        bits_next  = bits_reg;
        ov_next    = ov_reg && !m_ready;
        oval_next  = oval_reg;
        osing_next = osing_reg;
        osat_next  = osat_reg;
        olast_next = olast_reg;
        job_pop    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    order_next = job.order;
                    bank_next  = job.bank;
                    detph_next = 1'b1;
                    r_next     = '0;
                    c_next     = '0;
                    det_next   = '0;
                    term_next  = '0;
                    step_next  = '0;
                    acc_next   = '0;
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                unique case (step_reg)
                    2'd0: step_next = 2'd1;
                    2'd1: begin
                        x_next    = elem;
                        step_next = 2'd2;
                    end
                    2'd2: begin
                        p_next    = x_reg * elem;
                        step_next = 2'd3;
                    end
                    default: begin
                        acc_next  = term_neg ? acc_reg - COF_W'(pz) : acc_reg + COF_W'(pz);
                        step_next = 2'd0;
                        if (term_reg == 3'(TERMS - 1)) begin
                            state_next = ST_COF;
                        end else begin
                            term_next = term_reg + 3'd1;
                        end
                    end
                endcase
            end
            ST_COF: begin
                cof_next = acc_reg;
                if (detph_reg) begin
                    state_next = ST_DMUL;
                end else if (det_reg == '0) begin
                    sing_next  = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    sing_next  = 1'b0;
                    dq_next    = {cmag, FRAC_W'(0)};
                    rem_next   = '0;
                    dmag_next  = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
                    neg_next   = acc_reg[COF_W-1] ^ det_reg[DET_W-1];
                    bits_next  = DIV_LAST;
                    state_next = ST_DIV;
                end
            end
            ST_DMUL: begin
                det_next  = det_reg + DET_W'(ac);
                term_next = '0;
                step_next = '0;
                acc_next  = '0;
                state_next = ST_TERM;
                if (c_reg == lastpos) begin
                    detph_next = 1'b0;
                    oi_next    = '0;
                    oj_next    = '0;
                    r_next     = '0;
                    c_next     = '0;
                end else begin
                    c_next = c_reg + 2'd1;
                end
            end
            ST_DIV: begin
                rem_next  = ge ? DET_W'(shifted - {1'b0, dmag_reg}) : DET_W'(shifted);
                dq_next   = {dq_reg[QUO_W-2:0], ge};
                bits_next = bits_reg - 6'd1;
                if (bits_reg == '0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!ov_reg || m_ready) begin
                    ov_next    = 1'b1;
                    osing_next = sing_reg;
                    olast_next = is_last;
                    if (sing_reg) begin
                        oval_next = '0;
                        osat_next = 1'b0;
                    end else if (sat_pos) begin
                        oval_next = VAL_W'(32'h7FFF_FFFF);
                        osat_next = 1'b1;
                    end else if (sat_neg) begin
                        oval_next = VAL_W'(32'h8000_0000);
                        osat_next = 1'b1;
                    end else begin
                        oval_next = neg_reg ? VAL_W'(-dq_reg[VAL_W-1:0]) : dq_reg[VAL_W-1:0];
                        osat_next = 1'b0;
                    end
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        term_next  = '0;
                        step_next  = '0;
                        acc_next   = '0;
                        state_next = ST_TERM;
                        // cofactor (j, i) feeds inverse element (i, j)
                        if (oj_reg == lastpos) begin
                            oj_next = '0;
                            oi_next = oi_reg + 2'd1;
                            r_next  = '0;
                            c_next  = oi_reg + 2'd1;
                        end else begin
                            oj_next = oj_reg + 2'd1;
                            r_next  = oj_reg + 2'd1;
                            c_next  = oi_reg;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        order_reg <= order_next;
        bank_reg  <= bank_next;
        detph_reg <= detph_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        oi_reg    <= oi_next;
        oj_reg    <= oj_next;
        term_reg  <= term_next;
        step_reg  <= step_next;
        x_reg     <= x_next;
        p_reg     <= p_next;
        acc_reg   <= acc_next;
        cof_reg   <= cof_next;
        det_reg   <= det_next;
        rem_reg   <= rem_next;
        dmag_reg  <= dmag_next;
        dq_reg    <= dq_next;
        neg_reg   <= neg_next;
        sing_reg  <= sing_next;
        bits_reg  <= bits_next;
        oval_reg  <= oval_next;
        osing_reg <= osing_next;
        osat_reg  <= osat_next;
        olast_reg <= olast_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign m_valid         = ov_reg;
    assign m_inverse_value = oval_reg;
    assign m_singular      = osing_reg;
    assign m_saturated     = osat_reg;
    assign m_last          = olast_reg;

    `MIC_ASSERT_NOW(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, dmag_reg != '0,
                    "divide by zero")
    `MIC_ASSERT_NOW(a_singular_zero, aclk, aresetn, m_valid && m_singular,
                    m_inverse_value == '0 && !m_saturated, "singular beat not zero")
    `MIC_ASSERT_NEXT(a_pop_starts, aclk, aresetn, job_pop,
                     state_reg == ST_TERM && detph_reg, "job pop did not start expansion")

endmodule

`default_nettype wire

// ===== hdl/matrix_inverse_cofactor.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_cofactor
// Integer matrix inverse by adjugate over determinant, Q16.16 results.
// ----------------------------------------------------------------------------
// Elements stream in row-major, one beat per cycle while s_ready is high,
// into one of two matrix banks, so the next matrix loads while the engine
// works on the current one. The engine first computes the n first-row
// cofactors for the determinant, then one cofactor and one division per
// result: each cofactor is a sequence on one 12x12 and one 24x12 multiplier,
// each division runs on a restoring divider. A singular matrix skips the
// divider. Loading stalls only while both banks hold pending work.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_cofactor
    import mic_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_matrix_size,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ELEM_W-1:0] s_element,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [VAL_W-1:0]       m_inverse_value,
    output logic                   m_singular,
    output logic                   m_saturated,
    output logic                   m_last
);

    logic              ram_we;
    logic [IDX_W:0]    ram_waddr, ram_raddr;
    logic [ELEM_W-1:0] ram_wdata, ram_rdata;
    logic              push, pop, nonempty, busy, slot_free;
    job_t              push_job, head;
    logic [1:0]        q_count;

    assign slot_free = (q_count + 2'(busy)) < 2'd2;

    mic_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_matrix_size (cfg_matrix_size),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element       (s_element),
        .slot_free       (slot_free),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .push            (push),
        .push_job        (push_job)
    );

    mic_ram #(
        .WIDTH (12),
        .DEPTH (32)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mic_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty),
        .count    (q_count)
    );

    mic_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (nonempty),
        .job             (head),
        .job_pop         (pop),
        .busy            (busy),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inverse_value (m_inverse_value),
        .m_singular      (m_singular),
        .m_saturated     (m_saturated),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire
